// ===== hw/rtl/mme_pkg.sv =====
// Shared types, constants and helpers of the matrix multiply engine.
package mme_pkg;

  localparam int MaxDim   = 8;
  localparam int IdxW     = $clog2(MaxDim);
  localparam int DimW     = IdxW + 1;
  localparam int AddrW    = 2 * IdxW;
  localparam int ElemW    = 16;
  localparam int ProdW    = 2 * ElemW;
  localparam int SumW     = 40;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] RegLeftRows  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInnerSize = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRightCols = 2'd2;

  typedef enum logic [1:0] {
    OP_LEFT    = 2'd0,
    OP_RIGHT   = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // Effective sizes of the three dimensions.
  typedef struct packed {
    logic [DimW-1:0] nr;
    logic [DimW-1:0] nk;
    logic [DimW-1:0] nc;
  } dims_t;

  // Tag that travels with one multiply-accumulate step.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tag_t;

  // Store write strobes from the sequencer.
  typedef struct packed {
    logic left;
    logic right;
  } wr_t;

  // A size of zero counts as one and a size above the maximum counts as the maximum.
  function automatic logic [DimW-1:0] eff_dim(input logic [CfgDataW-1:0] d);
    logic [DimW-1:0] r;
    if (d == '0) begin
      r = DimW'(1);
    end else if (d > CfgDataW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = DimW'(d);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mme_store.sv =====
// One matrix store: 64 x 16 memory with registered read and per-entry valid bits.
module mme_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [mme_pkg::AddrW-1:0]    wr_addr,
  input  logic [mme_pkg::ElemW-1:0]    wr_data,
  input  logic [mme_pkg::AddrW-1:0]    rd_addr,
  output logic [mme_pkg::ElemW-1:0]    rd_data
);

  localparam int Depth = mme_pkg::MaxDim * mme_pkg::MaxDim;

  logic [mme_pkg::ElemW-1:0] mem [Depth];
  logic [Depth-1:0]          vld_r;
  logic [mme_pkg::ElemW-1:0] data_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_r   <= mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? data_r : '0;

endmodule

// ===== hw/rtl/mme_mac.sv =====
// Multiply-accumulate datapath: registered product, then accumulation.
module mme_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mme_pkg::tag_t                     tag_in,
  input  logic signed [mme_pkg::ElemW-1:0]  a,
  input  logic signed [mme_pkg::ElemW-1:0]  b,
  output logic                              done,
  output logic signed [mme_pkg::SumW-1:0]   sum
);

  mme_pkg::tag_t                     tag1_r;
  mme_pkg::tag_t                     tag2_r;
  logic signed [mme_pkg::ProdW-1:0]  prod_r;
  logic signed [mme_pkg::SumW-1:0]   acc_r;
  logic signed [mme_pkg::SumW-1:0]   acc_nxt;
  logic signed [mme_pkg::SumW-1:0]   prod_ext;

  // tag1 lines up with the store read data, tag2 with the product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    acc_r  <= acc_nxt;
  end

  assign prod_ext = mme_pkg::SumW'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (tag2_r.vld) begin
      acc_nxt = tag2_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

  assign done = tag2_r.vld & tag2_r.last;
  assign sum  = acc_nxt;

endmodule

// ===== hw/rtl/mme_ctrl.sv =====
// Sequencer: accepts beats, steers store writes and walks the product loops.
module mme_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mme_pkg::dims_t                 dims,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [mme_pkg::IdxW-1:0]       in_row_index,
  input  logic [mme_pkg::IdxW-1:0]       in_col_index,
  input  logic                           out_free,
  input  logic                           mac_done,
  output mme_pkg::wr_t                   wr,
  output logic [mme_pkg::AddrW-1:0]      left_rd_addr,
  output logic [mme_pkg::AddrW-1:0]      right_rd_addr,
  output mme_pkg::tag_t                  tag,
  output logic [mme_pkg::IdxW-1:0]       cur_row,
  output logic [mme_pkg::IdxW-1:0]       cur_col,
  output logic                           cur_final
);

  mme_pkg::state_t           state_r, state_nxt;
  logic [mme_pkg::IdxW-1:0]  i_r, i_nxt;
  logic [mme_pkg::IdxW-1:0]  j_r, j_nxt;
  logic [mme_pkg::IdxW-1:0]  k_r, k_nxt;
  logic                      accept;
  logic                      row_end, col_end, k_end;
  logic                      go;

  assign in_ready = (state_r == mme_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;

  assign row_end = ({1'b0, i_r} == dims.nr - mme_pkg::DimW'(1));
  assign col_end = ({1'b0, j_r} == dims.nc - mme_pkg::DimW'(1));
  assign k_end   = ({1'b0, k_r} == dims.nk - mme_pkg::DimW'(1));

  // A new entry starts only when the output register can take its result.
  assign go = (state_r == mme_pkg::ST_ISSUE) && ((k_r != '0) || out_free);

  always_comb begin
    wr = '0;
    if (accept) begin
      case (in_op)
        mme_pkg::OP_LEFT: begin
          wr.left = ({1'b0, in_row_index} < dims.nr) && ({1'b0, in_col_index} < dims.nk);
        end
        mme_pkg::OP_RIGHT: begin
          wr.right = ({1'b0, in_row_index} < dims.nk) && ({1'b0, in_col_index} < dims.nc);
        end
        default: begin
          wr = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      mme_pkg::ST_IDLE: begin
        if (accept && (in_op == mme_pkg::OP_COMPUTE)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = mme_pkg::ST_ISSUE;
        end
      end
      mme_pkg::ST_ISSUE: begin
        if (go) begin
          if (k_end) begin
            state_nxt = mme_pkg::ST_DRAIN;
          end else begin
            k_nxt = k_r + mme_pkg::IdxW'(1);
          end
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (mac_done) begin
          k_nxt = '0;
          if (row_end && col_end) begin
            state_nxt = mme_pkg::ST_IDLE;
          end else begin
            state_nxt = mme_pkg::ST_ISSUE;
            if (col_end) begin
              j_nxt = '0;
              i_nxt = i_r + mme_pkg::IdxW'(1);
            end else begin
              j_nxt = j_r + mme_pkg::IdxW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = mme_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  assign left_rd_addr  = {i_r, k_r};
  assign right_rd_addr = {k_r, j_r};

  assign tag.vld   = go;
  assign tag.first = (k_r == '0);
  assign tag.last  = k_end;

  assign cur_row   = i_r;
  assign cur_col   = j_r;
  assign cur_final = row_end & col_end;

endmodule

// ===== hw/rtl/matrix_multiply_engine.sv =====
// Top level of the matrix multiply engine: configuration, stores, datapath and output register.
//
// Write beats (op 0 or 1) land in one of two 64-entry stores, one per matrix, addressed by
// row and column; a write outside the configured size is dropped. A compute beat emits the
// left_rows x right_cols product in row-major order, one beat per entry, the final one
// flagged by out_last. For each entry the single read port of each store delivers one left
// and one right element per cycle into a registered 16x16 multiplier and a 40-bit
// accumulator, and the last product drains through the read latency and the multiplier
// stage; an entry does not start while the previous result still waits in the output
// register. No input beat is accepted during a compute. The stores read as zero after reset
// with no clearing pass. Sizes of zero count as one and sizes above eight count as eight;
// configuration must be written only while the block is idle; the block itself does not
// enforce this.
module matrix_multiply_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mme_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [mme_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [mme_pkg::IdxW-1:0]            in_row_index,
  input  logic [mme_pkg::IdxW-1:0]            in_col_index,
  input  logic signed [mme_pkg::ElemW-1:0]    in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mme_pkg::IdxW-1:0]            out_row,
  output logic [mme_pkg::IdxW-1:0]            out_col,
  output logic signed [mme_pkg::SumW-1:0]     out_sum,
  output logic                                out_last
);

  logic [mme_pkg::CfgDataW-1:0]     left_rows_r;
  logic [mme_pkg::CfgDataW-1:0]     inner_size_r;
  logic [mme_pkg::CfgDataW-1:0]     right_cols_r;
  mme_pkg::dims_t                   dims;

  mme_pkg::wr_t                     wr;
  mme_pkg::tag_t                    tag;
  logic [mme_pkg::AddrW-1:0]        left_rd_addr;
  logic [mme_pkg::AddrW-1:0]        right_rd_addr;
  logic [mme_pkg::AddrW-1:0]        wr_addr;
  logic [mme_pkg::ElemW-1:0]        left_rd_data;
  logic [mme_pkg::ElemW-1:0]        right_rd_data;
  logic                             mac_done;
  logic signed [mme_pkg::SumW-1:0]  mac_sum;
  logic [mme_pkg::IdxW-1:0]         cur_row;
  logic [mme_pkg::IdxW-1:0]         cur_col;
  logic                             cur_final;
  logic                             out_free;

  logic                             out_valid_r;
  logic [mme_pkg::IdxW-1:0]         out_row_r;
  logic [mme_pkg::IdxW-1:0]         out_col_r;
  logic signed [mme_pkg::SumW-1:0]  out_sum_r;
  logic                             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_rows_r  <= mme_pkg::CfgDataW'(mme_pkg::MaxDim);
      inner_size_r <= mme_pkg::CfgDataW'(mme_pkg::MaxDim);
      right_cols_r <= mme_pkg::CfgDataW'(mme_pkg::MaxDim);
    end else if (cfg_we) begin
      case (cfg_index)
        mme_pkg::RegLeftRows:  left_rows_r  <= cfg_data;
        mme_pkg::RegInnerSize: inner_size_r <= cfg_data;
        mme_pkg::RegRightCols: right_cols_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign dims.nr = mme_pkg::eff_dim(left_rows_r);
  assign dims.nk = mme_pkg::eff_dim(inner_size_r);
  assign dims.nc = mme_pkg::eff_dim(right_cols_r);

  assign out_free = !out_valid_r || out_ready;
  assign wr_addr  = {in_row_index, in_col_index};

  mme_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .dims          (dims),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .out_free      (out_free),
    .mac_done      (mac_done),
    .wr            (wr),
    .left_rd_addr  (left_rd_addr),
    .right_rd_addr (right_rd_addr),
    .tag           (tag),
    .cur_row       (cur_row),
    .cur_col       (cur_col),
    .cur_final     (cur_final)
  );

  mme_store u_left_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr.left),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (left_rd_addr),
    .rd_data (left_rd_data)
  );

  mme_store u_right_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr.right),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (right_rd_addr),
    .rd_data (right_rd_data)
  );

  mme_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_in (tag),
    .a      (left_rd_data),
    .b      (right_rd_data),
    .done   (mac_done),
    .sum    (mac_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mac_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_done) begin
      out_row_r  <= cur_row;
      out_col_r  <= cur_col;
      out_sum_r  <= mac_sum;
      out_last_r <= cur_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_sum   = out_sum_r;
  assign out_last  = out_last_r;

  // A finished sum must never overwrite a result that is still waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending output beat");

  // The accumulator only completes while a compute is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> !in_ready)
    else $error("accumulator completed while the sequencer was idle");

  // Store writes happen only while the sequencer is idle, never during a walk.
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr.left || wr.right) |=> !mac_done)
    else $error("store write overlapped a compute");

endmodule
